FILE: sv/mrs_pkg.sv
// shared constants and types for the sha-1 merkle root block
`default_nettype none
package mrs_pkg;
   localparam int MaxLeaves = 256;
   localparam int CountW = $clog2(MaxLeaves + 1);
   localparam int IdxW = $clog2(MaxLeaves);
   localparam int AddrW = $clog2(MaxLeaves * 5);

   typedef struct packed {
      logic load;
      logic rd_left;
      logic rd_right;
      logic hash_start;
      logic wr_hash;
      logic wr_copy;
      logic [IdxW-1:0] wr_idx;
      logic [IdxW-1:0] rd_idx;
   } cmd_type;

   typedef struct packed {
      logic hash_done;
   } stat_type;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      rol = (x << n) | (x >> (32 - n));
   endfunction
endpackage
`default_nettype wire

FILE: sv/mrs_datapath.sv
// node store, sha-1 round engine and node registers
`default_nettype none
module mrs_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire mrs_pkg::cmd_type cmd,
   output mrs_pkg::stat_type stat,
   input  wire logic [159:0] leaf,
   output logic [159:0] node
);
   import mrs_pkg::*;

   logic [159:0] mem [MaxLeaves];
   logic [159:0] rd_ff;
   logic [159:0] left_ff, left_in;
   logic [159:0] right_ff, right_in;
   logic [511:0] w_ff, w_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, a_in, b_in, c_in, d_in, e_in;
   logic [6:0] rnd_ff, rnd_in;
   logic busy_ff, busy_in, done_ff, done_in, rdv_ff;
   logic [1:0] rds_ff;
   logic [31:0] f, k, t, wn;
   logic [159:0] hash;

   always_ff @(posedge clock) begin
      if (cmd.load) mem[cmd.wr_idx] <= leaf;
      else if (cmd.wr_hash) mem[cmd.wr_idx] <= hash;
      else if (cmd.wr_copy) mem[cmd.wr_idx] <= rd_ff;
      rd_ff <= mem[cmd.rd_idx];
   end

   assign hash = {32'h67452301 + a_ff, 32'hEFCDAB89 + b_ff, 32'h98BADCFE + c_ff,
                  32'h10325476 + d_ff, 32'hC3D2E1F0 + e_ff};
   assign node = rd_ff;
   assign stat.hash_done = done_ff;

   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
      wn = rol(w_ff[511:480] ^ w_ff[447:416] ^ w_ff[255:224] ^ w_ff[95:64], 1);
      t = rol(a_ff, 5) + f + e_ff + k + w_ff[511:480];
      left_in = left_ff; right_in = right_ff;
      w_in = w_ff; rnd_in = rnd_ff; busy_in = busy_ff; done_in = 1'b0;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      if (rdv_ff && rds_ff[0]) left_in = rd_ff;
      if (rdv_ff && rds_ff[1]) right_in = rd_ff;
      if (cmd.hash_start) begin
         w_in = {left_ff, right_ff, 32'h80000000, 128'd0, 32'd320};
         a_in = 32'h67452301; b_in = 32'hEFCDAB89; c_in = 32'h98BADCFE;
         d_in = 32'h10325476; e_in = 32'hC3D2E1F0;
         rnd_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         w_in = {w_ff[479:0], wn};
         a_in = t; b_in = a_ff; c_in = rol(b_ff, 30); d_in = c_ff; e_in = d_ff;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; rdv_ff <= 1'b0; rnd_ff <= '0;
         rds_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; rnd_ff <= rnd_in;
         rdv_ff <= cmd.rd_left | cmd.rd_right;
         rds_ff <= {cmd.rd_right, cmd.rd_left};
      end
      left_ff <= left_in; right_ff <= right_in; w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end
endmodule
`default_nettype wire

FILE: sv/mrs_ctrl.sv
// sequencer for leaf loading and level-by-level reduction
`default_nettype none
module mrs_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_is_final,
   input  wire logic req_no_leaf,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [mrs_pkg::CountW-1:0] rsp_leaf_total,
   output logic rsp_overflowed,
   output logic rsp_zero,
   output mrs_pkg::cmd_type cmd,
   input  wire mrs_pkg::stat_type stat
);
   import mrs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RDL, S_RDR, S_WAITR, S_HASH, S_RUN, S_CPRD, S_CPWAIT, S_CPWR,
      S_NEXT, S_FIN, S_FINW, S_OUT
   } state_type;

   state_type state_ff;
   logic [CountW-1:0] cnt_ff, n_ff, i_ff, m_ff;
   logic drop_ff, zero_ff;
   logic take, store;

   assign req_ready = (state_ff == S_IDLE);
   assign take = req_valid && req_ready;
   assign store = take && !req_no_leaf && cnt_ff < CountW'(MaxLeaves);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_leaf_total = cnt_ff;
   assign rsp_overflowed = drop_ff;
   assign rsp_zero = zero_ff;

   always_comb begin
      cmd = '0;
      cmd.load = store;
      cmd.wr_idx = store ? cnt_ff[IdxW-1:0] : m_ff[IdxW-1:0];
      cmd.rd_idx = i_ff[IdxW-1:0];
      unique case (state_ff)
         S_RDL: cmd.rd_left = 1'b1;
         S_RDR: cmd.rd_right = 1'b1;
         S_HASH: cmd.hash_start = 1'b1;
         S_RUN: cmd.wr_hash = stat.hash_done;
         S_CPWR: cmd.wr_copy = 1'b1;
         S_FIN: cmd.rd_idx = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; drop_ff <= 1'b0; zero_ff <= 1'b0;
         n_ff <= '0; i_ff <= '0; m_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (take) begin
               if (store) cnt_ff <= cnt_ff + 1'b1;
               else if (!req_no_leaf) drop_ff <= 1'b1;
               if (req_is_final) begin
                  n_ff <= store ? cnt_ff + 1'b1 : cnt_ff;
                  zero_ff <= !store && cnt_ff == '0;
                  i_ff <= '0; m_ff <= '0;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               i_ff <= '0; m_ff <= '0;
               state_ff <= (n_ff > CountW'(1)) ? S_RDL : S_FIN;
            end
            S_RDL: if (i_ff + 1'b1 < n_ff) begin
               i_ff <= i_ff + 1'b1; state_ff <= S_RDR;
            end else if (i_ff < n_ff) state_ff <= S_CPRD;
            else begin
               n_ff <= m_ff; state_ff <= S_NEXT;
            end
            S_RDR: begin
               i_ff <= i_ff + 1'b1; state_ff <= S_WAITR;
            end
            S_WAITR: state_ff <= S_HASH;
            S_HASH: state_ff <= S_RUN;
            S_RUN: if (stat.hash_done) begin
               m_ff <= m_ff + 1'b1; state_ff <= S_RDL;
            end
            S_CPRD: state_ff <= S_CPWAIT;
            S_CPWAIT: state_ff <= S_CPWR;
            S_CPWR: begin
               n_ff <= m_ff + 1'b1; state_ff <= S_NEXT;
            end
            S_FIN: state_ff <= S_FINW;
            S_FINW: state_ff <= S_OUT;
            S_OUT: if (rsp_ready) begin
               cnt_ff <= '0; drop_ff <= 1'b0; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: sv/merkle_root_sha1_top.sv
// top level of the sha-1 merkle root block
// req channel: one leaf word per handshake as five 32-bit big-endian words;
//   req_no_leaf marks a word with no leaf, req_is_final closes the set.
// rsp channel: one root word per set with the leaf count and an overflow
//   flag; leaves beyond 256 are dropped and flagged.
// words are loaded one per cycle while the block is idle; after the final
//   word the tree is reduced with one shared 80-round sha-1 engine,
//   one pair combine at a time (N-1 combines for N leaves), level by level.
// the node store is a memory with one read and one write port, driven by
//   the sequencer; the hash engine runs one round per cycle.
// the root word is held on rsp until taken; while it waits no new word is
//   accepted. reset returns the block to an empty set.
`default_nettype none
module merkle_root_sha1_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [31:0] req_word0,
   input  wire logic [31:0] req_word1,
   input  wire logic [31:0] req_word2,
   input  wire logic [31:0] req_word3,
   input  wire logic [31:0] req_word4,
   input  wire logic req_is_final,
   input  wire logic req_no_leaf,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_root0,
   output logic [31:0] rsp_root1,
   output logic [31:0] rsp_root2,
   output logic [31:0] rsp_root3,
   output logic [31:0] rsp_root4,
   output logic [8:0] rsp_leaf_total,
   output logic rsp_overflowed
);
   import mrs_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [159:0] node;
   logic zero;

   mrs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_is_final, .req_no_leaf,
      .rsp_valid, .rsp_ready, .rsp_leaf_total, .rsp_overflowed,
      .rsp_zero(zero), .cmd, .stat
   );

   mrs_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .leaf({req_word0, req_word1, req_word2, req_word3, req_word4}),
      .node
   );

   assign rsp_root0 = zero ? '0 : node[159:128];
   assign rsp_root1 = zero ? '0 : node[127:96];
   assign rsp_root2 = zero ? '0 : node[95:64];
   assign rsp_root3 = zero ? '0 : node[63:32];
   assign rsp_root4 = zero ? '0 : node[31:0];
endmodule
`default_nettype wire

FILE: sv/mrs_checker.sv
// port-level checks for the merkle root block
`default_nettype none
module mrs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [8:0] rsp_leaf_total,
   input wire logic rsp_overflowed
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_leaf_total))
      else $error("result dropped");
   a_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_leaf_total <= 9'd256) else $error("count too large");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_leaf_total == 9'd256)
      else $error("overflow below full");
endmodule

bind merkle_root_sha1_top mrs_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_leaf_total, .rsp_overflowed
);
`default_nettype wire

FILE: tb/merkle_root_sha1_top_test.sv
// self-checking testbench for the sha-1 merkle root block
`default_nettype none
module merkle_root_sha1_top_test;
   import mrs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_word0 = '0, req_word1 = '0, req_word2 = '0, req_word3 = '0;
   logic [31:0] req_word4 = '0;
   logic req_is_final = 1'b0, req_no_leaf = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_root0, rsp_root1, rsp_root2, rsp_root3, rsp_root4;
   logic [8:0] rsp_leaf_total;
   logic rsp_overflowed;

   typedef struct {
      logic [31:0] root [5];
      logic [8:0] leaf_total;
      logic overflowed;
   } root_word_type;

   merkle_root_sha1_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   logic [31:0] leaf_nodes [MaxLeaves*5];
   int unsigned set_leaves = 0;
   logic set_dropped = 1'b0;
   root_word_type expected_roots [$];
   int errors = 0;
   int roots_seen = 0;
   int words_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 1'b0;
   int quiet_cycles = 0;

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void pair_digest(int li, int ri, output logic [31:0] dig [5]);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 5; i++) begin
         w[i] = leaf_nodes[li*5+i];
         w[i+5] = leaf_nodes[ri*5+i];
      end
      w[10] = 32'h8000_0000;
      for (int i = 11; i < 15; i++) w[i] = '0;
      w[15] = 32'd320;
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE;
      d = 32'h10325476; e = 32'hC3D2E1F0;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      dig[0] = 32'h67452301 + a; dig[1] = 32'hEFCDAB89 + b;
      dig[2] = 32'h98BADCFE + c; dig[3] = 32'h10325476 + d;
      dig[4] = 32'hC3D2E1F0 + e;
   endfunction

   function automatic void predict_root(logic [31:0] wd [5], logic fin, logic nl);
      root_word_type r;
      logic [31:0] dig [5];
      int n, m;
      if (!nl) begin
         if (set_leaves < MaxLeaves) begin
            for (int j = 0; j < 5; j++) leaf_nodes[set_leaves*5+j] = wd[j];
            set_leaves++;
         end else set_dropped = 1'b1;
      end
      if (!fin) return;
      n = set_leaves;
      for (int j = 0; j < 5; j++) r.root[j] = '0;
      while (n > 1) begin
         m = 0;
         for (int i = 0; i + 1 < n; i += 2) begin
            pair_digest(i, i + 1, dig);
            for (int j = 0; j < 5; j++) leaf_nodes[m*5+j] = dig[j];
            m++;
         end
         if (n % 2) begin
            for (int j = 0; j < 5; j++) leaf_nodes[m*5+j] = leaf_nodes[(n-1)*5+j];
            m++;
         end
         n = m;
      end
      if (set_leaves > 0)
         for (int j = 0; j < 5; j++) r.root[j] = leaf_nodes[j];
      r.leaf_total = set_leaves[8:0];
      r.overflowed = set_dropped;
      expected_roots.push_back(r);
      set_leaves = 0;
      set_dropped = 1'b0;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // valid stays up between back-to-back words and drops only when idling
   task automatic send_word(logic [31:0] wd [5], logic fin, logic nl);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_root(wd, fin, nl);
      req_valid <= 1'b1;
      req_word0 <= wd[0]; req_word1 <= wd[1]; req_word2 <= wd[2];
      req_word3 <= wd[3]; req_word4 <= wd[4];
      req_is_final <= fin; req_no_leaf <= nl;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_leaf(logic fin);
      logic [31:0] wd [5];
      for (int j = 0; j < 5; j++) wd[j] = $urandom;
      send_word(wd, fin, 1'b0);
   endtask

   task automatic send_marker(logic fin);
      logic [31:0] wd [5];
      for (int j = 0; j < 5; j++) wd[j] = $urandom;
      send_word(wd, fin, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_roots.size() > 0) @(posedge clock);
   endtask

   // a set of n leaves, closed either by the last leaf or by a bare marker
   task automatic send_set(int n, bit marker_end);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0) send_marker(1'b0);
         send_leaf(!marker_end && i == n - 1);
      end
      if (marker_end || n == 0) send_marker(1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            roots_seen++;
            if (expected_roots.size() == 0) begin
               $display("unexpected root word");
               errors++;
            end else begin
               root_word_type x;
               x = expected_roots.pop_front();
               if (rsp_root0 !== x.root[0]) report_mismatch("root0", rsp_root0, x.root[0]);
               if (rsp_root1 !== x.root[1]) report_mismatch("root1", rsp_root1, x.root[1]);
               if (rsp_root2 !== x.root[2]) report_mismatch("root2", rsp_root2, x.root[2]);
               if (rsp_root3 !== x.root[3]) report_mismatch("root3", rsp_root3, x.root[3]);
               if (rsp_root4 !== x.root[4]) report_mismatch("root4", rsp_root4, x.root[4]);
               if (rsp_leaf_total !== x.leaf_total)
                  report_mismatch("leaf_total", 32'(rsp_leaf_total), 32'(x.leaf_total));
               if (rsp_overflowed !== x.overflowed)
                  report_mismatch("overflowed", 32'(rsp_overflowed), 32'(x.overflowed));
            end
         end
         rsp_ready <= !hold_rsp && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 200000) begin
         $display("timeout");
         $display("merkle_root_sha1_top_test NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] wd [5];
      send_marker(1'b1);
      for (int j = 0; j < 5; j++) wd[j] = '1;
      send_word(wd, 1'b1, 1'b0);
      for (int j = 0; j < 5; j++) wd[j] = '0;
      send_word(wd, 1'b0, 1'b0);
      for (int j = 0; j < 5; j++) wd[j] = '1;
      send_word(wd, 1'b1, 1'b0);
      send_set(3, 1'b0);
      send_marker(1'b0);
      send_set(5, 1'b1);
      drain();
   endtask

   task automatic test_full_store();
      for (int i = 0; i < MaxLeaves + 2; i++) send_leaf(1'b0);
      send_leaf(1'b1);
      send_set(MaxLeaves, 1'b1);
      drain();
   endtask

   task automatic test_random(int words);
      int goal;
      goal = words_sent + words;
      while (words_sent < goal) begin
         if ($urandom_range(9) == 0) send_set($urandom_range(1, 64), $urandom_range(1));
         else send_set($urandom_range(0, 9), $urandom_range(1));
      end
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_set(2, 1'b0);
      join
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random(70);
      send_idle_pct = 74;
      test_random(70);
      send_idle_pct = 0; stall_pct = 74;
      test_random(70);
      send_idle_pct = 37; stall_pct = 37;
      test_random(70);
      send_idle_pct = 0; stall_pct = 0;
      test_backpressure();
      repeat (200) @(posedge clock);
      $display("sent %0d words, checked %0d roots incl. empty, single, odd and full sets",
               words_sent, roots_seen);
      $display("idle and stall mixes covered, plus a long output hold-off");
      if (errors == 0 && expected_roots.size() == 0)
         $display("merkle_root_sha1_top_test OK");
      else
         $display("merkle_root_sha1_top_test NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
sv/mrs_pkg.sv
sv/mrs_datapath.sv
sv/mrs_ctrl.sv
sv/merkle_root_sha1_top.sv
sv/mrs_checker.sv
tb/merkle_root_sha1_top_test.sv
